>>> rtl/core/modbus_rtu_slave_engine_unit_assert.svh
// Assertion macros for the Modbus RTU slave engine.
// Used by the top level only; needs no package.
`ifndef MODBUS_RTU_SLAVE_ENGINE_UNIT_ASSERT_SVH
`define MODBUS_RTU_SLAVE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MRSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrse assertion failed");

// Next-cycle implication.
`define MRSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrse assertion failed");

`endif

>>> rtl/core/mrse_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU slave engine.
// No dependencies.
package mrse_pkg;

   localparam int RX_DEPTH_DEF   = 256;
   localparam int TABLE_DEPTH    = 1024;
   localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
   localparam int MAX_READ_WORDS = 29;

   localparam logic [1:0] CMD_RX_BYTE = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_LWRITE  = 2'd2;
   localparam logic [1:0] CMD_LREAD   = 2'd3;

   localparam logic [2:0] FS_REPLIED    = 3'd0;
   localparam logic [2:0] FS_NO_REPLY   = 3'd1;
   localparam logic [2:0] FS_BAD_FUNC   = 3'd2;
   localparam logic [2:0] FS_CRC        = 3'd3;
   localparam logic [2:0] FS_OTHER_ADDR = 3'd4;
   localparam logic [2:0] FS_OVERLEN    = 3'd5;
   localparam logic [2:0] FS_READ_LARGE = 3'd6;

   localparam logic [7:0] FN_READ_COILS  = 8'd1;
   localparam logic [7:0] FN_READ_HOLD   = 8'd3;
   localparam logic [7:0] FN_WRITE_ONE   = 8'd6;
   localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

   localparam logic [15:0] W16_LIMIT = 16'd90;
   localparam logic [15:0] TF_FIRST  = 16'd10;
   localparam logic [15:0] TF_LAST   = 16'd16;
   localparam logic [15:0] TF_BIAS   = 16'd9;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'd2;
   localparam logic [9:0] SILENCE_RESET    = 10'd4;

   localparam int   CSR_AW          = 3;
   localparam logic CSR_IDX_SLAVE   = 1'b0;
   localparam logic CSR_IDX_SILENCE = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  rx_byte;
      logic [9:0]  table_index;
      logic [15:0] table_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic [2:0]  frame_status;
      logic [2:0]  time_field;
      logic [15:0] table_word;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LREAD,
      ST_LEMIT,
      ST_SCAN_RD,
      ST_SCAN_USE,
      ST_DECIDE,
      ST_REFUSE,
      ST_WR6,
      ST_W16_RDH,
      ST_W16_HI,
      ST_W16_LO,
      ST_TX_HDR,
      ST_TX_RD,
      ST_TX_WHI,
      ST_TX_WLO,
      ST_TX_CRCL,
      ST_TX_CRCH
   } state_type;

   typedef enum logic [2:0] {
      OS_REFUSE,
      OS_LOCAL,
      OS_HDR,
      OS_WHI,
      OS_WLO,
      OS_CRCL,
      OS_CRCH
   } osel_type;

   typedef enum logic [1:0] {
      DEC_REFUSE,
      DEC_READ,
      DEC_WR6,
      DEC_WR16
   } dec_type;

   typedef struct packed {
      logic     accept;
      logic     clr_step;
      logic     scan_init;
      logic     scan_rd;
      logic     scan_use;
      logic     decide;
      logic     w6;
      logic     w16_rdh;
      logic     w16_hi;
      logic     w16_lo;
      logic     tbl_local;
      logic     emit;
      osel_type osel;
      logic     frame_end;
   } ctl_cmd_type;

   typedef struct packed {
      logic    clr_done;
      logic    req_lread;
      logic    tick_fire;
      logic    overflow;
      logic    scan_end;
      dec_type dec;
      logic    hdr_last;
      logic    need_words;
      logic    w16_done;
   } ctl_sts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/mrse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/mrse_datapath.sv
// Datapath: receive buffer, register table, frame scan, CRC, reply bytes.
// Depends on mrse_pkg and mrse_ram.
module mrse_datapath #(
   parameter int RX_DEPTH = mrse_pkg::RX_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrse_pkg::ctl_cmd_type cmd,
   output mrse_pkg::ctl_sts_type sts,
   input  mrse_pkg::req_type    req_data,
   input  logic [7:0]           slave_addr,
   input  logic [9:0]           silence_ticks,
   input  logic                 out_free,
   output mrse_pkg::rsp_type    out_data
);
   import mrse_pkg::*;

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam logic [2:0] HDR_LAST_READ  = 3'd2;
   localparam logic [2:0] HDR_LAST_WRITE = 3'd5;

   logic [RX_CW-1:0]    rx_count_ff, rx_count_in;
   logic                rx_ovf_ff, rx_ovf_in;
   logic [9:0]          silence_ff, silence_in;
   logic [TABLE_AW-1:0] clr_ff, clr_in;
   logic [RX_CW-1:0]    idx_ff, idx_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          hdr_ff [6];
   logic [7:0]          hdr_in [6];
   logic [7:0]          cb_lo_ff, cb_lo_in, cb_hi_ff, cb_hi_in;
   logic [2:0]          code_ff, code_in;
   logic                is_read_ff, is_read_in;
   logic [15:0]         addr_ff, addr_in, qty_ff, qty_in;
   logic [2:0]          tf_ff, tf_in;
   logic [6:0]          k_ff, k_in;
   logic [7:0]          bp_ff, bp_in;
   logic                ok_ff, ok_in;
   logic [7:0]          hi_ff, hi_in;
   logic [2:0]          hcnt_ff, hcnt_in;
   logic [9:0]          lidx_ff, lidx_in;

   logic                rx_we;
   logic [RX_AW-1:0]    rx_raddr;
   logic [7:0]          rx_rdata;
   logic                tbl_we;
   logic [TABLE_AW-1:0] tbl_waddr, tbl_raddr, addr_k;
   logic [15:0]         tbl_wdata, tbl_rdata;

   logic                pending, room, fire;
   logic [RX_CW:0]      i1, i2, cnt_x;
   logic [10:0]         bp_x, cnt_w;
   logic [7:0]          fn, ok_byte, hbyte;
   logic [15:0]         a_w, q_w, k_w;
   logic                crc_bad;
   dec_type             dec;
   logic [2:0]          dec_code;

   assign pending = (rx_count_ff != '0) || rx_ovf_ff;
   assign room    = rx_count_ff < RX_CW'(RX_DEPTH);
   assign fire    = cmd.emit & out_free;
   assign i1      = {1'b0, idx_ff} + (RX_CW + 1)'(1);
   assign i2      = {1'b0, idx_ff} + (RX_CW + 1)'(2);
   assign cnt_x   = {1'b0, rx_count_ff};
   assign bp_x    = 11'(bp_ff);
   assign cnt_w   = 11'(rx_count_ff);
   assign ok_byte = ok_ff ? rx_rdata : 8'h00;
   assign addr_k  = addr_ff[TABLE_AW-1:0] + TABLE_AW'(k_ff);
   assign k_w     = {9'b0, k_ff};

   assign fn      = hdr_ff[1];
   assign a_w     = {hdr_ff[2], hdr_ff[3]};
   assign q_w     = {hdr_ff[4], hdr_ff[5]};
   assign crc_bad = (crc_ff[7:0] != cb_lo_ff) || (crc_ff[15:8] != cb_hi_ff);

   // frame checks, in priority order
   always_comb begin
      dec      = DEC_REFUSE;
      dec_code = FS_REPLIED;
      if (rx_ovf_ff) begin
         dec_code = FS_OVERLEN;
      end else if (hdr_ff[0] != slave_addr) begin
         dec_code = FS_OTHER_ADDR;
      end else if ((rx_count_ff < RX_CW'(4)) || crc_bad) begin
         dec_code = FS_CRC;
      end else if (fn == FN_READ_COILS) begin
         dec_code = FS_NO_REPLY;
      end else if (fn == FN_READ_HOLD) begin
         if (q_w > 16'(MAX_READ_WORDS)) begin
            dec_code = FS_READ_LARGE;
         end else begin
            dec = DEC_READ;
         end
      end else if (fn == FN_WRITE_ONE) begin
         dec = DEC_WR6;
      end else if (fn == FN_WRITE_MULTI) begin
         dec = DEC_WR16;
      end else begin
         dec_code = FS_BAD_FUNC;
      end
   end

   always_comb begin
      hbyte = slave_addr;
      if (is_read_ff) begin
         case (hcnt_ff)
            3'd0:    hbyte = slave_addr;
            3'd1:    hbyte = FN_READ_HOLD;
            default: hbyte = {qty_ff[6:0], 1'b0};
         endcase
      end else if (hcnt_ff != 3'd0) begin
         hbyte = hdr_ff[hcnt_ff];
      end
   end

   always_comb begin
      out_data = '0;
      case (cmd.osel)
         OS_REFUSE: begin
            out_data.last_of_run  = 1'b1;
            out_data.frame_status = code_ff;
         end
         OS_LOCAL: begin
            out_data.last_of_run  = 1'b1;
            out_data.frame_status = FS_NO_REPLY;
            out_data.table_word   = tbl_rdata;
         end
         OS_HDR: begin
            out_data.tx_byte    = hbyte;
            out_data.byte_valid = 1'b1;
            out_data.time_field = tf_ff;
         end
         OS_WHI: begin
            out_data.tx_byte    = tbl_rdata[15:8];
            out_data.byte_valid = 1'b1;
            out_data.time_field = tf_ff;
         end
         OS_WLO: begin
            out_data.tx_byte    = tbl_rdata[7:0];
            out_data.byte_valid = 1'b1;
            out_data.time_field = tf_ff;
         end
         OS_CRCL: begin
            out_data.tx_byte    = crc_ff[7:0];
            out_data.byte_valid = 1'b1;
            out_data.time_field = tf_ff;
         end
         OS_CRCH: begin
            out_data.tx_byte     = crc_ff[15:8];
            out_data.byte_valid  = 1'b1;
            out_data.last_of_run = 1'b1;
            out_data.time_field  = tf_ff;
         end
         default: out_data = '0;
      endcase
   end

   always_comb begin
      rx_count_in = rx_count_ff;
      rx_ovf_in   = rx_ovf_ff;
      silence_in  = silence_ff;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      crc_in      = crc_ff;
      hdr_in      = hdr_ff;
      cb_lo_in    = cb_lo_ff;
      cb_hi_in    = cb_hi_ff;
      code_in     = code_ff;
      is_read_in  = is_read_ff;
      addr_in     = addr_ff;
      qty_in      = qty_ff;
      tf_in       = tf_ff;
      k_in        = k_ff;
      bp_in       = bp_ff;
      ok_in       = ok_ff;
      hi_in       = hi_ff;
      hcnt_in     = hcnt_ff;
      lidx_in     = lidx_ff;

      if (cmd.clr_step) begin
         clr_in = clr_ff + TABLE_AW'(1);
      end
      if (cmd.accept) begin
         lidx_in = req_data.table_index;
         case (req_data.command)
            CMD_RX_BYTE: begin
               silence_in = '0;
               if (room) begin
                  rx_count_in = rx_count_ff + RX_CW'(1);
               end else begin
                  rx_ovf_in = 1'b1;
               end
            end
            CMD_TICK: begin
               if (pending && !sts.tick_fire) begin
                  silence_in = silence_ff + 10'd1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.scan_init) begin
         idx_in   = '0;
         crc_in   = CRC_INIT;
         cb_lo_in = '0;
         cb_hi_in = '0;
         for (int j = 0; j < 6; j++) begin
            hdr_in[j] = '0;
         end
      end
      if (cmd.scan_use) begin
         if (i2 < cnt_x) begin
            crc_in = crc_byte(crc_ff, rx_rdata);
         end
         if (i2 == cnt_x) begin
            cb_lo_in = rx_rdata;
         end
         if (i1 == cnt_x) begin
            cb_hi_in = rx_rdata;
         end
         if (idx_ff < RX_CW'(6)) begin
            hdr_in[idx_ff[2:0]] = rx_rdata;
         end
         idx_in = idx_ff + RX_CW'(1);
      end
      if (cmd.decide) begin
         code_in    = dec_code;
         is_read_in = (dec == DEC_READ);
         addr_in    = a_w;
         qty_in     = q_w;
         tf_in      = '0;
         if ((dec == DEC_WR6 || dec == DEC_WR16) && a_w >= TF_FIRST && a_w <= TF_LAST) begin
            tf_in = 3'(a_w - TF_BIAS);
         end
         crc_in  = CRC_INIT;
         k_in    = '0;
         bp_in   = 8'd7;
         hcnt_in = '0;
      end
      if (cmd.w16_rdh || cmd.w16_hi) begin
         ok_in = bp_x < cnt_w;
         bp_in = bp_ff + 8'd1;
      end
      if (cmd.w16_hi) begin
         hi_in = ok_byte;
      end
      if (cmd.w16_lo) begin
         k_in = k_ff + 7'd1;
      end
      if (fire) begin
         if (cmd.osel == OS_HDR || cmd.osel == OS_WHI || cmd.osel == OS_WLO) begin
            crc_in = crc_byte(crc_ff, out_data.tx_byte);
         end
         if (cmd.osel == OS_HDR) begin
            hcnt_in = hcnt_ff + 3'd1;
         end
         if (cmd.osel == OS_WLO) begin
            k_in = k_ff + 7'd1;
         end
      end
      if (cmd.frame_end) begin
         rx_count_in = '0;
         rx_ovf_in   = 1'b0;
         silence_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff <= '0;
         rx_ovf_ff   <= 1'b0;
         silence_ff  <= '0;
         clr_ff      <= '0;
      end else begin
         rx_count_ff <= rx_count_in;
         rx_ovf_ff   <= rx_ovf_in;
         silence_ff  <= silence_in;
         clr_ff      <= clr_in;
      end
      idx_ff     <= idx_in;
      crc_ff     <= crc_in;
      hdr_ff     <= hdr_in;
      cb_lo_ff   <= cb_lo_in;
      cb_hi_ff   <= cb_hi_in;
      code_ff    <= code_in;
      is_read_ff <= is_read_in;
      addr_ff    <= addr_in;
      qty_ff     <= qty_in;
      tf_ff      <= tf_in;
      k_ff       <= k_in;
      bp_ff      <= bp_in;
      ok_ff      <= ok_in;
      hi_ff      <= hi_in;
      hcnt_ff    <= hcnt_in;
      lidx_ff    <= lidx_in;
   end

   // buffer ports
   assign rx_we    = cmd.accept && (req_data.command == CMD_RX_BYTE) && room;
   assign rx_raddr = cmd.scan_rd ? idx_ff[RX_AW-1:0] : RX_AW'(bp_ff);

   // table write port: clearing pass, local write, function 06, function 16
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = addr_k;
      tbl_wdata = '0;
      if (cmd.clr_step) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_ff;
      end else if (cmd.accept && req_data.command == CMD_LWRITE) begin
         tbl_we    = 1'b1;
         tbl_waddr = TABLE_AW'(req_data.table_index);
         tbl_wdata = req_data.table_value;
      end else if (cmd.w6) begin
         tbl_we    = 1'b1;
         tbl_waddr = addr_ff[TABLE_AW-1:0];
         tbl_wdata = qty_ff;
      end else if (cmd.w16_lo) begin
         tbl_we    = 1'b1;
         tbl_wdata = {hi_ff, ok_byte};
      end
   end

   assign tbl_raddr = cmd.tbl_local ? TABLE_AW'(lidx_ff) : addr_k;

   mrse_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_count_ff[RX_AW-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_addr (rx_raddr),
      .rd_data (rx_rdata)
   );

   mrse_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   always_comb begin
      sts            = '0;
      sts.clr_done   = (clr_ff == TABLE_AW'(TABLE_DEPTH - 1));
      sts.req_lread  = (req_data.command == CMD_LREAD);
      sts.tick_fire  = (req_data.command == CMD_TICK) && pending &&
                       (silence_ff >= silence_ticks);
      sts.overflow   = rx_ovf_ff;
      sts.scan_end   = (idx_ff == rx_count_ff);
      sts.dec        = dec;
      sts.hdr_last   = is_read_ff ? (hcnt_ff == HDR_LAST_READ) : (hcnt_ff == HDR_LAST_WRITE);
      sts.need_words = is_read_ff && (k_w != qty_ff);
      sts.w16_done   = (qty_ff >= W16_LIMIT) || (k_w == qty_ff);
   end
endmodule

>>> rtl/core/mrse_ctrl.sv
// Controller state machine: sequences accept, frame scan, table writes and reply.
// Depends on mrse_pkg.
module mrse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  out_free,
   input  mrse_pkg::ctl_sts_type sts,
   output mrse_pkg::ctl_cmd_type cmd
);
   import mrse_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (sts.clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid && sts.req_lread) begin
               state_in = ST_LREAD;
            end else if (req_valid && sts.tick_fire) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_LREAD:    state_in = ST_LEMIT;
         ST_LEMIT:    if (out_free) state_in = ST_IDLE;
         ST_SCAN_RD:  state_in = (sts.scan_end || sts.overflow) ? ST_DECIDE : ST_SCAN_USE;
         ST_SCAN_USE: state_in = ST_SCAN_RD;
         ST_DECIDE: begin
            unique case (sts.dec)
               DEC_READ: state_in = ST_TX_HDR;
               DEC_WR6:  state_in = ST_WR6;
               DEC_WR16: state_in = ST_W16_RDH;
               default:  state_in = ST_REFUSE;
            endcase
         end
         ST_REFUSE:   if (out_free) state_in = ST_IDLE;
         ST_WR6:      state_in = ST_TX_HDR;
         ST_W16_RDH:  state_in = sts.w16_done ? ST_TX_HDR : ST_W16_HI;
         ST_W16_HI:   state_in = ST_W16_LO;
         ST_W16_LO:   state_in = ST_W16_RDH;
         ST_TX_HDR:   if (out_free && sts.hdr_last) state_in = ST_TX_RD;
         ST_TX_RD:    state_in = sts.need_words ? ST_TX_WHI : ST_TX_CRCL;
         ST_TX_WHI:   if (out_free) state_in = ST_TX_WLO;
         ST_TX_WLO:   if (out_free) state_in = ST_TX_RD;
         ST_TX_CRCL:  if (out_free) state_in = ST_TX_CRCH;
         ST_TX_CRCH:  if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:    cmd.clr_step = 1'b1;
         ST_IDLE: begin
            cmd.accept    = req_valid;
            cmd.scan_init = 1'b1;
         end
         ST_LREAD:    cmd.tbl_local = 1'b1;
         ST_LEMIT: begin
            cmd.tbl_local = 1'b1;
            cmd.emit      = 1'b1;
            cmd.osel      = OS_LOCAL;
         end
         ST_SCAN_RD:  cmd.scan_rd = 1'b1;
         ST_SCAN_USE: cmd.scan_use = 1'b1;
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_REFUSE: begin
            cmd.emit      = 1'b1;
            cmd.osel      = OS_REFUSE;
            cmd.frame_end = 1'b1;
         end
         ST_WR6:      cmd.w6 = 1'b1;
         ST_W16_RDH:  cmd.w16_rdh = !sts.w16_done;
         ST_W16_HI:   cmd.w16_hi = 1'b1;
         ST_W16_LO:   cmd.w16_lo = 1'b1;
         ST_TX_HDR: begin
            cmd.emit = 1'b1;
            cmd.osel = OS_HDR;
         end
         ST_TX_RD:    cmd.emit = 1'b0;
         ST_TX_WHI: begin
            cmd.emit = 1'b1;
            cmd.osel = OS_WHI;
         end
         ST_TX_WLO: begin
            cmd.emit = 1'b1;
            cmd.osel = OS_WLO;
         end
         ST_TX_CRCL: begin
            cmd.emit = 1'b1;
            cmd.osel = OS_CRCL;
         end
         ST_TX_CRCH: begin
            cmd.emit      = 1'b1;
            cmd.osel      = OS_CRCH;
            cmd.frame_end = 1'b1;
         end
         default:     cmd = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> rtl/core/modbus_rtu_slave_engine_unit.sv
// Top level of the Modbus RTU slave engine: CSR port, result register, core.
// Depends on mrse_pkg, mrse_ctrl, mrse_datapath and the assertion macro header.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------
//   req     | in        | req_valid/req_stall | mrse_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | mrse_pkg::rsp_type
//   csr     | in/out    | APB psel/penable    | slave_address, silence_ticks
//
// A received byte, a local write or a quiet tick is taken while idle; a local
// read does a table read and an emit step. A tick that ends a frame scans the
// buffer, a read and a use step per byte (one read port), decides, writes (one
// step for function 06; a check, high and low step per word and a last check for
// function 16), then replies: header bytes, a read step per table word plus one
// more, CRC bytes. After reset the register table is cleared, one entry a cycle,
// with req_stall high. Stalls on rsp hold the engine in its current reply step.
`include "modbus_rtu_slave_engine_unit_assert.svh"

module modbus_rtu_slave_engine_unit #(
   parameter int RX_DEPTH = mrse_pkg::RX_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mrse_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mrse_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mrse_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import mrse_pkg::*;

   logic [7:0]  slave_addr_ff, slave_addr_in;
   logic [9:0]  silence_ff, silence_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        out_free, load;
   ctl_cmd_type cmd;
   ctl_sts_type sts;
   rsp_type     out_data;
   logic        lread_take, status_only;

   // Configuration: write completes on the access cycle; pready stays high.
   assign csr_pready = 1'b1;

   always_comb begin
      slave_addr_in = slave_addr_ff;
      silence_in    = silence_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            CSR_IDX_SLAVE:   slave_addr_in = csr_pwdata[7:0];
            CSR_IDX_SILENCE: silence_in    = csr_pwdata[9:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_SLAVE:   csr_prdata = {24'b0, slave_addr_ff};
         CSR_IDX_SILENCE: csr_prdata = {22'b0, silence_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Result register: take a new transfer whenever the held one is gone or leaving.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = cmd.emit && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = load ? out_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
         silence_ff    <= SILENCE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slave_addr_ff <= slave_addr_in;
         silence_ff    <= silence_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mrse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrse_datapath #(.RX_DEPTH(RX_DEPTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_data      (req_data),
      .slave_addr    (slave_addr_ff),
      .silence_ticks (silence_ff),
      .out_free      (out_free),
      .out_data      (out_data)
   );

   assign lread_take  = req_valid && !req_stall && (req_data.command == CMD_LREAD);
   assign status_only = rsp_valid_ff && !rsp_data_ff.byte_valid;

   // A local read takes over the engine from the following cycle.
   `MRSE_ASSERT_NEXT(a_lread_busy, clock, reset, lread_take, req_stall)
   // The clearing pass holds off input right after reset.
   `MRSE_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), req_stall)
   // A result without a response byte is always the only one of its run.
   `MRSE_ASSERT_NOW(a_status_is_last, clock, reset, status_only, rsp_data_ff.last_of_run)
endmodule
